// ----- design/spq_pkg.sv -----
// Package for the sorted priority queue: widths, depth, operation and
// status codes, and the command struct from controller to datapath.
// No dependencies.
package spq_pkg;

  localparam int DEPTH = 8;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int PRI_W = 16;
  localparam int ST_W  = 2;
  localparam int OCC_W = 4;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  // operation select carried on in_tuser
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic exec;    // run one operation this cycle and load the result
    logic is_del;  // operation is a delete
  } spq_cmd_t;

endpackage

// ----- design/sorted_priority_queue.sv -----
// Sorted priority queue of DEPTH key/priority entries, smallest priority first.
// The result is valid in the cycle after the input transfer; one item per cycle
// while the result side takes every transfer, set by the single compare-and-shift
// pass over the cell row. Reset (rst_n low, synchronous) empties the queue and
// the result register; stored cells are not cleared. Depends on spq_pkg,
// spq_ctrl and spq_dp.
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] entry_key, [47:32] entry_priority
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [1:0] status, [33:2] out_key,
                                  // [49:34] out_priority, [53:50] occupancy
);
  import spq_pkg::*;

  spq_cmd_t                cmd;
  logic [ST_W-1:0]         res_status;
  logic signed [KEY_W-1:0] res_key;
  logic signed [PRI_W-1:0] res_pri;
  logic [OCC_W-1:0]        res_occ;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_key     ($signed(in_tdata[KEY_W-1:0])),
    .in_pri     ($signed(in_tdata[KEY_W+PRI_W-1:KEY_W])),
    .res_status (res_status),
    .res_key    (res_key),
    .res_pri    (res_pri),
    .res_occ    (res_occ)
  );

  // pack result fields, lowest first, pad to whole bytes
  assign out_tdata = {2'b00, res_occ, res_pri, res_key, res_status};

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted transfer did not produce a result");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while result stalled");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_status == ST_OVERFLOW) |-> (res_occ == OCC_W'(DEPTH)))
    else $error("overflow reported while queue not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_status == ST_UNDERFLOW) |-> (res_occ == '0))
    else $error("underflow reported while queue not empty");
`endif

endmodule

// ----- design/spq_ctrl.sv -----
// Controller for the sorted priority queue: tracks whether the result
// register holds a transfer not yet taken and issues the execute command.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_func,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_EMPTY = 2'b01,
    S_FULL  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // accept whenever the result register is free or drains this cycle
  assign in_tready  = (state_r == S_EMPTY) || out_tready;
  assign out_tvalid = (state_r == S_FULL);
  assign cmd.exec   = in_tvalid && in_tready;
  assign cmd.is_del = (in_func == FUNC_DELETE);

  // advance: fill on execute, drain on output transfer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_EMPTY: begin
        if (cmd.exec) state_nxt = S_FULL;
      end
      S_FULL: begin
        if (cmd.exec) state_nxt = S_FULL;
        else if (out_tready) state_nxt = S_EMPTY;
      end
      default: state_nxt = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/spq_dp.sv -----
// Datapath for the sorted priority queue: a row of compare-and-shift
// cells, the entry count and the result register. Depends on spq_pkg.
module spq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spq_pkg::spq_cmd_t                   cmd,
  input  logic signed [spq_pkg::KEY_W-1:0]    in_key,
  input  logic signed [spq_pkg::PRI_W-1:0]    in_pri,
  output logic [spq_pkg::ST_W-1:0]            res_status,
  output logic signed [spq_pkg::KEY_W-1:0]    res_key,
  output logic signed [spq_pkg::PRI_W-1:0]    res_pri,
  output logic [spq_pkg::OCC_W-1:0]           res_occ
);
  import spq_pkg::*;

  logic signed [KEY_W-1:0] key_r [DEPTH];
  logic signed [PRI_W-1:0] pri_r [DEPTH];
  logic signed [KEY_W-1:0] key_nxt [DEPTH];
  logic signed [PRI_W-1:0] pri_nxt [DEPTH];
  logic [DEPTH-1:0]        gt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    full, empty;
  logic [ST_W-1:0]         status_nxt;
  logic signed [KEY_W-1:0] rkey_nxt;
  logic signed [PRI_W-1:0] rpri_nxt;

  logic [ST_W-1:0]         status_r;
  logic signed [KEY_W-1:0] rkey_r;
  logic signed [PRI_W-1:0] rpri_r;
  logic [OCC_W-1:0]        occ_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  // per-cell compare: stored entry sorts after the new one
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign gt[i] = (CNT_W'(i) < cnt_r) && (pri_r[i] > in_pri);
  end

  // per-cell next value for insert (shift down or load) and delete (shift up)
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic take_prev, load_new;
    if (i == 0) begin : g_head
      assign take_prev = 1'b0;
      assign load_new  = gt[i] || empty;
    end else begin : g_body
      assign take_prev = gt[i-1];
      assign load_new  = !gt[i-1] && (gt[i] || (CNT_W'(i) == cnt_r));
    end

    always_comb begin
      key_nxt[i] = key_r[i];
      pri_nxt[i] = pri_r[i];
      if (cmd.is_del) begin
        if (i < DEPTH - 1) begin
          key_nxt[i] = key_r[(i < DEPTH - 1) ? i + 1 : i];
          pri_nxt[i] = pri_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end else if (!full) begin
        if (take_prev) begin
          key_nxt[i] = key_r[(i > 0) ? i - 1 : i];
          pri_nxt[i] = pri_r[(i > 0) ? i - 1 : i];
        end else if (load_new) begin
          key_nxt[i] = in_key;
          pri_nxt[i] = in_pri;
        end
      end
    end
  end

  // status, removed entry and count after the operation
  always_comb begin
    status_nxt = ST_OK;
    rkey_nxt   = '0;
    rpri_nxt   = '0;
    cnt_nxt    = cnt_r;
    if (cmd.is_del) begin
      if (empty) begin
        status_nxt = ST_UNDERFLOW;
      end else begin
        rkey_nxt = key_r[0];
        rpri_nxt = pri_r[0];
        cnt_nxt  = cnt_r - 1'b1;
      end
    end else begin
      if (full) begin
        status_nxt = ST_OVERFLOW;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // cells and result register hold unless an operation executes
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        key_r[i] <= key_nxt[i];
        pri_r[i] <= pri_nxt[i];
      end
      status_r <= status_nxt;
      rkey_r   <= rkey_nxt;
      rpri_r   <= rpri_nxt;
      occ_r    <= OCC_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign res_status = status_r;
  assign res_key    = rkey_r;
  assign res_pri    = rpri_r;
  assign res_occ    = occ_r;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sorted_priority_queue: a shadow copy of the sorted
// list predicts status, removed entry and occupancy for every transfer.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb;
  import spq_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] key;
    logic [PRI_W-1:0] pri;
    logic [OCC_W-1:0] occ;
  } pq_result_t;

  // Shadow of the queue contents plus the results still owed by the block
  class pq_shadow;
    logic [KEY_W-1:0]        shadow_keys[DEPTH];
    logic signed [PRI_W-1:0] shadow_pris[DEPTH];
    int                      shadow_count;
    pq_result_t              owed_results[$];
    int                      errors;

    function new();
      shadow_count = 0;
      errors = 0;
    endfunction

    function int owed();
      return owed_results.size();
    endfunction

    task report(input string msg);
      if (errors < 40) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Apply one accepted operation to the shadow list and queue its result
    function void apply_op(input logic op, input logic [KEY_W-1:0] key,
                           input logic signed [PRI_W-1:0] pri);
      pq_result_t r;
      int i;
      r = '0;
      r.status = ST_OK;
      if (op == FUNC_INSERT) begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          // shift larger priorities up; equal ones stay ahead
          i = shadow_count;
          while (i > 0 && shadow_pris[i-1] > pri) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pris[i] = shadow_pris[i-1];
            i--;
          end
          shadow_keys[i] = key;
          shadow_pris[i] = pri;
          shadow_count++;
        end
      end else begin
        if (shadow_count == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.key = shadow_keys[0];
          r.pri = shadow_pris[0];
          for (i = 1; i < shadow_count; i++) begin
            shadow_keys[i-1] = shadow_keys[i];
            shadow_pris[i-1] = shadow_pris[i];
          end
          shadow_count--;
        end
      end
      r.occ = OCC_W'(shadow_count);
      owed_results.push_back(r);
    endfunction

    // Compare one result transfer against the oldest owed result
    task check_result(input logic [OUT_DATA_W-1:0] data);
      pq_result_t want;
      logic [ST_W-1:0]  got_status;
      logic [KEY_W-1:0] got_key;
      logic [PRI_W-1:0] got_pri;
      logic [OCC_W-1:0] got_occ;
      got_status = data[1:0];
      got_key    = data[33:2];
      got_pri    = data[49:34];
      got_occ    = data[53:50];
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result 0x%014h", data));
      end else begin
        want = owed_results.pop_front();
        if (got_status !== want.status)
          report($sformatf("status %0d, want %0d", got_status, want.status));
        if (got_key !== want.key)
          report($sformatf("key 0x%08h, want 0x%08h", got_key, want.key));
        if (got_pri !== want.pri)
          report($sformatf("priority 0x%04h, want 0x%04h", got_pri, want.pri));
        if (got_occ !== want.occ)
          report($sformatf("occupancy %0d, want %0d", got_occ, want.occ));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [31:0] entry_key, [47:32] entry_priority
  logic                  in_tuser;   // [0] func
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [1:0] status, [33:2] out_key,
                                     // [49:34] out_priority, [53:50] occupancy

  pq_shadow shadow;
  bit       send_idle;
  bit       recv_stall;

  sorted_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Note input transfers before checking result transfers on each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        shadow.apply_op(in_tuser, in_tdata[31:0], in_tdata[47:32]);
      if (out_tvalid && out_tready)
        shadow.check_result(out_tdata);
    end
  end

  // Result side: stall a random number of cycles before each transfer
  initial begin
    int stall;
    out_tready <= 1'b0;
    recv_stall = 1'b1;
    repeat (6) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_stall = !recv_stall;
      stall = recv_stall ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function int draw_gap();
    return send_idle ? $urandom_range(0, 17) : 0;
  endfunction

  // Present one item after an optional gap and hold it until the transfer
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                           input logic [PRI_W-1:0] pri);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pri, key};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (shadow.owed() != 0);
  endtask

  function logic [PRI_W-1:0] pick_priority(input bit narrow);
    if (!narrow) return PRI_W'($urandom());
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom_range(0, 4)) - 16'd2;
    endcase
  endfunction

  initial begin
    int insert_pct;
    bit narrow;
    shadow = new();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= FUNC_INSERT;
    send_idle  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: delete from empty, fill with extremes and ties, overflow,
    // then empty the queue and delete once more
    send_item(FUNC_DELETE, $urandom(), PRI_W'($urandom()));
    send_item(FUNC_INSERT, 32'h8000_0000, 16'h7fff);
    send_item(FUNC_INSERT, 32'h7fff_ffff, 16'h8000);
    send_item(FUNC_INSERT, 32'h0000_0000, 16'h0000);
    send_item(FUNC_INSERT, 32'hffff_ffff, 16'h0000);
    send_item(FUNC_INSERT, 32'h0000_1234, 16'h0000);
    send_item(FUNC_INSERT, 32'ha5a5_a5a5, 16'hffff);
    send_item(FUNC_INSERT, 32'h5a5a_5a5a, 16'h0001);
    send_item(FUNC_INSERT, 32'hffff_ffff, 16'h8000);
    send_item(FUNC_INSERT, 32'h1357_9bdf, 16'h0000);
    send_idle = 1'b1;
    repeat (DEPTH + 1) send_item(FUNC_DELETE, $urandom(), PRI_W'($urandom()));
    drain_results();

    // Random phases: fill-heavy, balanced and drain-heavy mixes
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0:       insert_pct = 75;
        1:       insert_pct = 50;
        2:       insert_pct = 30;
        default: insert_pct = $urandom_range(35, 65);
      endcase
      narrow    = $urandom_range(0, 1);
      send_idle = $urandom_range(0, 2) != 0;
      repeat (100) begin
        send_item(($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_DELETE,
                  $urandom(), pick_priority(narrow));
      end
      if (ph % 3 == 2) drain_results();
    end

    // Wait for the last results, then a few cycles for stray transfers
    in_tvalid <= 1'b0;
    do @(posedge clk); while (shadow.owed() != 0);
    repeat (20) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
